FILE: rtl/thread_activity_watchdog_table_assert.svh
// assertion macros for the activity watchdog table checker
// expects aclk and aresetn in the scope where a macro is used
`ifndef THREAD_ACTIVITY_WATCHDOG_TABLE_ASSERT_SVH
`define THREAD_ACTIVITY_WATCHDOG_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define TWDT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TWDT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/twdt_pkg.sv
// shared types and codes for the activity watchdog table
// used by the controller, the datapath and the top level
package twdt_pkg;

    localparam int ID_BITS     = 31;
    localparam int CMD_BITS    = 2;
    localparam int STATUS_BITS = 2;

    // input command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_CHECK  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_DROPPED   = 2'd3
    } result_code_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic add;
        logic scan;
        logic finish;
    } ctl_t;

    // datapath to controller status
    typedef struct packed {
        logic in_is_add;
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/thread_activity_watchdog_table.sv
// top level of the activity watchdog table: controller plus datapath
// depends on twdt_pkg, twdt_ctrl and twdt_datapath
//
//   channel   ports                     direction   carries
//   s_        s_valid / s_ready         in          command and one task observation
//   m_        m_valid / m_ready         out         status, wake flag, echoed id
//
// add: entry written in the add state, result registered in the finish state, then idle
// remove and check: entries read one per cycle through the single read port and
// written back compacted in place; fill count and result are registered in the finish
// state, then the controller returns to idle for the next transaction
// reset empties the table at once (fill count cleared, no clearing pass)
// a waiting result does not block the input; the next result stalls until it is taken
module thread_activity_watchdog_table
    import twdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CMD_BITS-1:0]    s_command,
    input  logic [ID_BITS-1:0]     s_task_id,
    input  logic [TIME_BITS-1:0]   s_timeout_us,
    input  logic [TIME_BITS-1:0]   s_now_us,
    input  logic [TIME_BITS-1:0]   s_kernel_count,
    input  logic [TIME_BITS-1:0]   s_user_count,
    input  logic                   s_is_running,
    input  logic                   s_task_exists,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_BITS-1:0] m_status,
    output logic                   m_wake,
    output logic [ID_BITS-1:0]     m_echo_id
);

    ctl_t  ctl;
    stat_t stat;

    // sequencing
    twdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    // table storage and arithmetic
    twdt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctl            (ctl),
        .stat           (stat),
        .s_command      (s_command),
        .s_task_id      (s_task_id),
        .s_timeout_us   (s_timeout_us),
        .s_now_us       (s_now_us),
        .s_kernel_count (s_kernel_count),
        .s_user_count   (s_user_count),
        .s_is_running   (s_is_running),
        .s_task_exists  (s_task_exists),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_wake         (m_wake),
        .m_echo_id      (m_echo_id)
    );

endmodule

FILE: rtl/twdt_ctrl.sv
// sequencing state machine of the activity watchdog table
// depends on twdt_pkg for the state type and the command/status structs
module twdt_ctrl
    import twdt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output ctl_t  ctl
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = stat.in_is_add ? ST_ADD : ST_SCAN;
                end
            end
            ST_ADD: begin
                state_next = ST_FINISH;
            end
            ST_SCAN: begin
                if (stat.scan_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        ctl     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
            end
            ST_ADD: begin
                ctl.add = 1'b1;
            end
            ST_SCAN: begin
                ctl.scan = 1'b1;
            end
            ST_FINISH: begin
                ctl.finish = stat.out_free;
            end
            default: begin
                ctl = '0;
            end
        endcase
    end

endmodule

FILE: rtl/twdt_datapath.sv
// entry memory, item register, scan pointers and result register
// depends on twdt_pkg for codes and the command/status structs
module twdt_datapath
    import twdt_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 48
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctl_t                   ctl,
    output stat_t                  stat,
    input  logic [CMD_BITS-1:0]    s_command,
    input  logic [ID_BITS-1:0]     s_task_id,
    input  logic [TIME_BITS-1:0]   s_timeout_us,
    input  logic [TIME_BITS-1:0]   s_now_us,
    input  logic [TIME_BITS-1:0]   s_kernel_count,
    input  logic [TIME_BITS-1:0]   s_user_count,
    input  logic                   s_is_running,
    input  logic                   s_task_exists,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [STATUS_BITS-1:0] m_status,
    output logic                   m_wake,
    output logic [ID_BITS-1:0]     m_echo_id
);

    localparam int ADDR_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(TABLE_DEPTH);
    localparam int EXP_BITS  = TIME_BITS + 1;

    // entry memory
    logic [ID_BITS-1:0]   mem_id      [TABLE_DEPTH];
    logic [TIME_BITS-1:0] mem_timeout [TABLE_DEPTH];
    logic [TIME_BITS-1:0] mem_kernel  [TABLE_DEPTH];
    logic [TIME_BITS-1:0] mem_user    [TABLE_DEPTH];
    logic [EXP_BITS-1:0]  mem_expiry  [TABLE_DEPTH];

    // held item
    cmd_t                 cmd_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [TIME_BITS-1:0] timeout_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] kern_reg;
    logic [TIME_BITS-1:0] user_reg;
    logic                 running_reg;
    logic                 exists_reg;

    // table control
    logic [CNT_BITS-1:0]  count_reg;
    logic [CNT_BITS-1:0]  rd_ptr_reg;
    logic [CNT_BITS-1:0]  wr_ptr_reg;
    logic                 rd_valid_reg;
    logic                 found_reg;
    logic                 wake_acc_reg;
    result_code_t         add_status_reg;

    // registered read data
    logic [ID_BITS-1:0]   rd_id_reg;
    logic [TIME_BITS-1:0] rd_timeout_reg;
    logic [TIME_BITS-1:0] rd_kernel_reg;
    logic [TIME_BITS-1:0] rd_user_reg;
    logic [EXP_BITS-1:0]  rd_expiry_reg;

    // result register
    logic                   m_valid_reg;
    logic [STATUS_BITS-1:0] m_status_reg;
    logic                   m_wake_reg;
    logic [ID_BITS-1:0]     m_echo_id_reg;

    logic                 rd_issue;
    logic                 is_remove;
    logic                 is_check;
    logic                 match;
    logic                 drop;
    logic                 keep;
    logic                 active;
    logic                 expired;
    logic                 present_hit;
    logic                 wake_hit;
    logic                 add_ok;
    logic [TIME_BITS-1:0] renew_base;
    logic [EXP_BITS-1:0]  renew;
    logic                 wr_en;
    logic [ADDR_BITS-1:0] wr_addr;
    logic [TIME_BITS-1:0] wr_timeout;
    logic [TIME_BITS-1:0] wr_kernel;
    logic [TIME_BITS-1:0] wr_user;
    logic [EXP_BITS-1:0]  wr_expiry;
    logic [ID_BITS-1:0]   wr_id;
    result_code_t         result_status;

    // status to the controller
    assign stat.in_is_add = (cmd_t'(s_command) == CMD_ADD);
    assign stat.scan_done = !(rd_ptr_reg < count_reg) && !rd_valid_reg;
    assign stat.out_free  = !m_valid_reg || m_ready;

    // item capture
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg     <= cmd_t'(s_command);
            id_reg      <= s_task_id;
            timeout_reg <= s_timeout_us;
            now_reg     <= s_now_us;
            kern_reg    <= s_kernel_count;
            user_reg    <= s_user_count;
            running_reg <= s_is_running;
            exists_reg  <= s_task_exists;
        end
    end

    // per-entry decisions on the registered read data
    assign rd_issue    = ctl.scan && (rd_ptr_reg < count_reg);
    assign is_remove   = (cmd_reg == CMD_REMOVE);
    assign is_check    = (cmd_reg == CMD_CHECK);
    assign match       = rd_valid_reg && (rd_id_reg == id_reg);
    assign drop        = match && ((is_remove && !found_reg) || (is_check && !exists_reg));
    assign keep        = rd_valid_reg && !drop;
    assign active      = (kern_reg != rd_kernel_reg) || (user_reg != rd_user_reg) || running_reg;
    assign expired     = ({1'b0, now_reg} >= rd_expiry_reg);
    assign present_hit = match && is_check && exists_reg;
    assign wake_hit    = present_hit && !active && expired;
    assign add_ok      = exists_reg && (count_reg < DEPTH_CNT);

    // shared expiry adder
    assign renew_base = ctl.add ? timeout_reg : rd_timeout_reg;
    assign renew      = {1'b0, now_reg} + {1'b0, renew_base};

    // memory write port selection
    always_comb begin
        if (ctl.add) begin
            wr_en      = add_ok;
            wr_addr    = count_reg[ADDR_BITS-1:0];
            wr_id      = id_reg;
            wr_timeout = timeout_reg;
            wr_kernel  = kern_reg;
            wr_user    = user_reg;
            wr_expiry  = renew;
        end else begin
            wr_en      = ctl.scan && keep && (is_remove || is_check);
            wr_addr    = wr_ptr_reg[ADDR_BITS-1:0];
            wr_id      = rd_id_reg;
            wr_timeout = rd_timeout_reg;
            wr_kernel  = (present_hit && active) ? kern_reg : rd_kernel_reg;
            wr_user    = (present_hit && active) ? user_reg : rd_user_reg;
            wr_expiry  = (present_hit && (active || expired)) ? renew : rd_expiry_reg;
        end
    end

    // memory write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_id[wr_addr]      <= wr_id;
            mem_timeout[wr_addr] <= wr_timeout;
            mem_kernel[wr_addr]  <= wr_kernel;
            mem_user[wr_addr]    <= wr_user;
            mem_expiry[wr_addr]  <= wr_expiry;
        end
    end

    // memory read
    always_ff @(posedge aclk) begin
        if (rd_issue) begin
            rd_id_reg      <= mem_id[rd_ptr_reg[ADDR_BITS-1:0]];
            rd_timeout_reg <= mem_timeout[rd_ptr_reg[ADDR_BITS-1:0]];
            rd_kernel_reg  <= mem_kernel[rd_ptr_reg[ADDR_BITS-1:0]];
            rd_user_reg    <= mem_user[rd_ptr_reg[ADDR_BITS-1:0]];
            rd_expiry_reg  <= mem_expiry[rd_ptr_reg[ADDR_BITS-1:0]];
        end
    end

    // scan pointers, flags and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            wake_acc_reg   <= 1'b0;
            add_status_reg <= STATUS_OK;
        end else if (ctl.load) begin
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            rd_valid_reg <= 1'b0;
            found_reg    <= 1'b0;
            wake_acc_reg <= 1'b0;
        end else if (ctl.add) begin
            if (!exists_reg) begin
                add_status_reg <= STATUS_NOT_FOUND;
            end else if (!add_ok) begin
                add_status_reg <= STATUS_FULL;
            end else begin
                add_status_reg <= STATUS_OK;
                count_reg      <= count_reg + 1'b1;
            end
        end else if (ctl.scan) begin
            rd_valid_reg <= rd_issue;
            if (rd_issue) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (keep) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (match && (is_remove || is_check)) begin
                found_reg <= 1'b1;
            end
            if (wake_hit) begin
                wake_acc_reg <= 1'b1;
            end
        end else if (ctl.finish && (cmd_reg != CMD_ADD)) begin
            count_reg <= wr_ptr_reg;
        end
    end

    // result status
    always_comb begin
        case (cmd_reg)
            CMD_ADD: begin
                result_status = add_status_reg;
            end
            CMD_REMOVE: begin
                result_status = found_reg ? STATUS_OK : STATUS_NOT_FOUND;
            end
            CMD_CHECK: begin
                if (!exists_reg) begin
                    result_status = found_reg ? STATUS_DROPPED : STATUS_NOT_FOUND;
                end else begin
                    result_status = found_reg ? STATUS_OK : STATUS_NOT_FOUND;
                end
            end
            default: begin
                result_status = STATUS_OK;
            end
        endcase
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (ctl.finish) begin
            m_status_reg  <= result_status;
            m_wake_reg    <= wake_acc_reg;
            m_echo_id_reg <= id_reg;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_wake    = m_wake_reg;
    assign m_echo_id = m_echo_id_reg;

endmodule

FILE: rtl/twdt_checker.sv
// port-level checks for the activity watchdog table, bound to the top level
// depends on twdt_pkg and thread_activity_watchdog_table_assert.svh
`include "thread_activity_watchdog_table_assert.svh"

module twdt_checker
    import twdt_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [STATUS_BITS-1:0] m_status,
    input logic                   m_wake,
    input logic [ID_BITS-1:0]     m_echo_id
);

    // one transaction at a time: the input side closes after an acceptance
    `TWDT_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "s_ready high after accept")

    // a wake only comes with a successful check
    `TWDT_ASSERT_IMP(a_wake_ok, m_valid && m_wake, m_status == STATUS_OK, "wake with bad status")

    // a stalled result holds
    `TWDT_ASSERT_NXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_wake) && $stable(m_echo_id), "stalled result changed")

endmodule

bind thread_activity_watchdog_table twdt_checker u_twdt_checker (.*);

FILE: verif/thread_activity_watchdog_table_tb.sv
// testbench for thread_activity_watchdog_table: directed and random transactions,
// with a table predictor and an in-order result check; depends on twdt_pkg and the rtl
module thread_activity_watchdog_table_tb;
    import twdt_pkg::*;

    localparam int DEPTH  = 16;
    localparam int TIME_W = 48;
    localparam logic [ID_BITS-1:0] ID_MAX   = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX = '1;

    typedef struct {
        cmd_t                command;
        logic [ID_BITS-1:0]  task_id;
        logic [TIME_W-1:0]   timeout_us;
        logic [TIME_W-1:0]   now_us;
        logic [TIME_W-1:0]   kernel_count;
        logic [TIME_W-1:0]   user_count;
        logic                is_running;
        logic                task_exists;
    } watch_req_t;

    typedef struct {
        result_code_t        status;
        logic                wake;
        logic [ID_BITS-1:0]  echo_id;
    } watch_resp_t;

    typedef struct {
        logic [ID_BITS-1:0]  id;
        logic [TIME_W-1:0]   timeout_us;
        logic [TIME_W-1:0]   kernel_count;
        logic [TIME_W-1:0]   user_count;
        logic [TIME_W:0]     expiry_us;
    } watch_entry_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [CMD_BITS-1:0]    s_command = '0;
    logic [ID_BITS-1:0]     s_task_id = '0;
    logic [TIME_W-1:0]      s_timeout_us = '0;
    logic [TIME_W-1:0]      s_now_us = '0;
    logic [TIME_W-1:0]      s_kernel_count = '0;
    logic [TIME_W-1:0]      s_user_count = '0;
    logic                   s_is_running = 1'b0;
    logic                   s_task_exists = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [STATUS_BITS-1:0] m_status;
    logic                   m_wake;
    logic [ID_BITS-1:0]     m_echo_id;

    // watched task table as the block should hold it, oldest entry first
    watch_entry_t watch_table[DEPTH];
    int           watch_fill = 0;

    watch_resp_t  expected_responses[$];
    watch_resp_t  oldest_response;
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           ready_stall_pct = 0;

    thread_activity_watchdog_table #(
        .TABLE_DEPTH(DEPTH),
        .TIME_BITS  (TIME_W)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_task_id     (s_task_id),
        .s_timeout_us  (s_timeout_us),
        .s_now_us      (s_now_us),
        .s_kernel_count(s_kernel_count),
        .s_user_count  (s_user_count),
        .s_is_running  (s_is_running),
        .s_task_exists (s_task_exists),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_wake        (m_wake),
        .m_echo_id     (m_echo_id)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[TIME_W-1:0];
    endfunction

    function automatic logic [ID_BITS-1:0] rand_id();
        logic [31:0] raw;
        raw = $urandom;
        return raw[ID_BITS-1:0];
    endfunction

    function automatic watch_req_t make_req(input cmd_t command, input logic [ID_BITS-1:0] id,
                                            input logic [TIME_W-1:0] timeout_us,
                                            input logic [TIME_W-1:0] now_us,
                                            input logic [TIME_W-1:0] kernel_count,
                                            input logic [TIME_W-1:0] user_count,
                                            input logic is_running, input logic task_exists);
        watch_req_t req;
        req.command      = command;
        req.task_id      = id;
        req.timeout_us   = timeout_us;
        req.now_us       = now_us;
        req.kernel_count = kernel_count;
        req.user_count   = user_count;
        req.is_running   = is_running;
        req.task_exists  = task_exists;
        return req;
    endfunction

    // applies one command to the table and returns the response it must give
    function automatic watch_resp_t predict_watch_response(input watch_req_t req);
        watch_resp_t resp;
        int          hit;
        int          keep;
        logic        found;
        resp.status  = STATUS_OK;
        resp.wake    = 1'b0;
        resp.echo_id = req.task_id;
        hit   = -1;
        keep  = 0;
        found = 1'b0;
        case (req.command)
            CMD_ADD: begin
                if (!req.task_exists) begin
                    resp.status = STATUS_NOT_FOUND;
                end else if (watch_fill >= DEPTH) begin
                    resp.status = STATUS_FULL;
                end else begin
                    watch_table[watch_fill].id           = req.task_id;
                    watch_table[watch_fill].timeout_us   = req.timeout_us;
                    watch_table[watch_fill].kernel_count = req.kernel_count;
                    watch_table[watch_fill].user_count   = req.user_count;
                    watch_table[watch_fill].expiry_us    = {1'b0, req.now_us}
                                                         + {1'b0, req.timeout_us};
                    watch_fill++;
                end
            end
            CMD_REMOVE: begin
                // oldest match goes, later entries move up
                for (int i = 0; i < watch_fill; i++) begin
                    if (hit < 0 && watch_table[i].id == req.task_id) hit = i;
                end
                if (hit < 0) begin
                    resp.status = STATUS_NOT_FOUND;
                end else begin
                    for (int j = hit; j + 1 < watch_fill; j++) watch_table[j] = watch_table[j + 1];
                    watch_fill--;
                end
            end
            CMD_CHECK: begin
                if (!req.task_exists) begin
                    // vanished task: compact the table without its entries
                    for (int i = 0; i < watch_fill; i++) begin
                        if (watch_table[i].id == req.task_id) begin
                            found = 1'b1;
                        end else begin
                            watch_table[keep] = watch_table[i];
                            keep++;
                        end
                    end
                    watch_fill  = keep;
                    resp.status = found ? STATUS_DROPPED : STATUS_NOT_FOUND;
                end else begin
                    for (int i = 0; i < watch_fill; i++) begin
                        if (watch_table[i].id == req.task_id) begin
                            found = 1'b1;
                            if (req.kernel_count != watch_table[i].kernel_count ||
                                req.user_count != watch_table[i].user_count || req.is_running) begin
                                watch_table[i].kernel_count = req.kernel_count;
                                watch_table[i].user_count   = req.user_count;
                                watch_table[i].expiry_us    = {1'b0, req.now_us}
                                                            + {1'b0, watch_table[i].timeout_us};
                            end else if ({1'b0, req.now_us} >= watch_table[i].expiry_us) begin
                                resp.wake = 1'b1;
                                watch_table[i].expiry_us    = {1'b0, req.now_us}
                                                            + {1'b0, watch_table[i].timeout_us};
                            end
                        end
                    end
                    resp.status = found ? STATUS_OK : STATUS_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        return resp;
    endfunction

    // drives one transaction and records its expected response once accepted
    task automatic send_watch_request(input watch_req_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_command      <= req.command;
        s_task_id      <= req.task_id;
        s_timeout_us   <= req.timeout_us;
        s_now_us       <= req.now_us;
        s_kernel_count <= req.kernel_count;
        s_user_count   <= req.user_count;
        s_is_running   <= req.is_running;
        s_task_exists  <= req.task_exists;
        do @(posedge aclk); while (!s_ready);
        expected_responses.push_back(predict_watch_response(req));
    endtask

    // random backpressure on the result side
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= ready_stall_pct);
    end

    // compare each accepted result with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_responses.size() == 0) begin
                $display("%0t: unexpected result status %0d wake %0d id %h", $time,
                         m_status, m_wake, m_echo_id);
                mismatch_count++;
            end else begin
                oldest_response = expected_responses.pop_front();
                if (m_status !== oldest_response.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             oldest_response.status, m_status);
                    mismatch_count++;
                end
                if (m_wake !== oldest_response.wake) begin
                    $display("%0t: wake expected %0d actual %0d", $time,
                             oldest_response.wake, m_wake);
                    mismatch_count++;
                end
                if (m_echo_id !== oldest_response.echo_id) begin
                    $display("%0t: echo_id expected %h actual %h", $time,
                             oldest_response.echo_id, m_echo_id);
                    mismatch_count++;
                end
            end
        end
    end

    // field extremes, every command, single entries
    task automatic test_add_remove_basics();
        send_watch_request(make_req(CMD_ADD, 31'h1234, 48'd50, 48'd100, 48'd1, 48'd1, 1'b0, 1'b0));
        send_watch_request(make_req(CMD_ADD, ID_MAX, TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX,
                                    1'b1, 1'b1));
        send_watch_request(make_req(CMD_ADD, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_REMOVE, 31'd5, '0, '0, '0, '0, 1'b0, 1'b1));
        // zero timeout: expiry equals now, so idle check wakes at once
        send_watch_request(make_req(CMD_CHECK, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        // expiry past the top of the time range is never reached
        send_watch_request(make_req(CMD_CHECK, ID_MAX, '0, TIME_MAX, TIME_MAX, TIME_MAX,
                                    1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, ID_MAX, '0, TIME_MAX, TIME_MAX, TIME_MAX,
                                    1'b1, 1'b1));
        send_watch_request(make_req(CMD_CHECK, ID_MAX, '0, 48'd3, '0, TIME_MAX, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, ID_MAX, '0, 48'd4, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd42, '0, '0, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd42, '0, '0, '0, '0, 1'b0, 1'b0));
        send_watch_request(make_req(CMD_REMOVE, '0, '0, '0, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_REMOVE, ID_MAX, '0, '0, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_NOP, rand_id(), rand_time(), rand_time(), rand_time(),
                                    rand_time(), 1'b1, 1'b1));
    endtask

    // several entries sharing one id, per-entry expiry and oldest-first remove
    task automatic test_duplicate_ids();
        send_watch_request(make_req(CMD_ADD, 31'd7, 48'd10, 48'd1000, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_ADD, 31'd7, 48'd100, 48'd1000, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_ADD, 31'd9, 48'd1, 48'd1000, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd7, '0, 48'd1009, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd7, '0, 48'd1010, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd7, '0, 48'd1100, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_REMOVE, 31'd7, '0, '0, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd7, '0, 48'd1200, 48'd5, 48'd6, 1'b0, 1'b0));
        send_watch_request(make_req(CMD_CHECK, 31'd9, '0, 48'd1200, 48'd5, 48'd6, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_CHECK, 31'd9, '0, 48'd1200, 48'd5, 48'd6, 1'b0, 1'b0));
    endtask

    // fill the table, overflow it, then empty it through vanished tasks
    task automatic test_table_full();
        logic [ID_BITS-1:0] fill_id;
        for (int i = 0; i < DEPTH; i++) begin
            fill_id = 31'd21 + ID_BITS'(i % 3);
            send_watch_request(make_req(CMD_ADD, fill_id, 48'($urandom_range(0, 50)), 48'd20,
                                        48'd1, 48'd1, 1'b0, 1'b1));
        end
        send_watch_request(make_req(CMD_ADD, 31'd30, 48'd5, 48'd20, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_ADD, 31'd30, 48'd5, 48'd20, '0, '0, 1'b0, 1'b0));
        send_watch_request(make_req(CMD_REMOVE, 31'd22, '0, '0, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_ADD, 31'd30, 48'd5, 48'd20, '0, '0, 1'b0, 1'b1));
        send_watch_request(make_req(CMD_ADD, 31'd31, 48'd5, 48'd20, '0, '0, 1'b0, 1'b1));
        for (int i = 0; i < 3; i++) begin
            send_watch_request(make_req(CMD_CHECK, 31'd21 + ID_BITS'(i), '0, 48'd90, '0, '0,
                                        1'b0, 1'b0));
        end
        send_watch_request(make_req(CMD_CHECK, 31'd30, '0, 48'd90, '0, '0, 1'b0, 1'b0));
    endtask

    // mostly well-formed traffic on a small pool of tasks, with some noise
    task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
        watch_req_t          req;
        logic [ID_BITS-1:0]  pool_id[6];
        logic [TIME_W-1:0]   pool_kernel[6];
        logic [TIME_W-1:0]   pool_user[6];
        logic [TIME_W-1:0]   clock_us;
        int                  slot;
        int                  pick;
        send_idle_pct   = idle_pct;
        ready_stall_pct = stall_pct;
        for (int i = 0; i < 6; i++) begin
            pool_id[i]     = rand_id();
            pool_kernel[i] = rand_time();
            pool_user[i]   = rand_time();
        end
        clock_us = rand_time();
        if ($urandom_range(3) != 0) begin
            clock_us[TIME_W-1:TIME_W-4] = '0;
        end else begin
            clock_us[TIME_W-1:20] = '1;
        end
        for (int n = 0; n < n_items; n++) begin
            clock_us += TIME_W'($urandom_range(0, 12));
            slot = $urandom_range(0, 5);
            pick = $urandom_range(99);
            req = make_req(CMD_CHECK, pool_id[slot], TIME_W'($urandom_range(0, 40)), clock_us,
                           pool_kernel[slot], pool_user[slot], 1'b0, 1'b1);
            if (pick < 20) begin
                req.command     = CMD_ADD;
                req.task_exists = ($urandom_range(9) != 0);
            end else if (pick < 30) begin
                req.command = CMD_REMOVE;
                if ($urandom_range(3) == 0) req.task_id = rand_id();
            end else if (pick < 85) begin
                req.is_running  = ($urandom_range(4) == 0);
                req.task_exists = ($urandom_range(19) != 0);
                if ($urandom_range(9) < 3) begin
                    if ($urandom_range(1) == 0) begin
                        pool_kernel[slot] += TIME_W'($urandom_range(1, 5));
                    end else begin
                        pool_user[slot] += TIME_W'($urandom_range(1, 5));
                    end
                    req.kernel_count = pool_kernel[slot];
                    req.user_count   = pool_user[slot];
                end
            end else begin
                // noise: unused command or fully random fields
                req = make_req(pick < 88 ? CMD_NOP : cmd_t'(CMD_BITS'($urandom_range(3))),
                               rand_id(), rand_time(), rand_time(), rand_time(), rand_time(),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            send_watch_request(req);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_add_remove_basics();
        test_duplicate_ids();
        test_table_full();
        test_random_traffic(90, 0, 0);
        test_random_traffic(90, 69, 0);
        test_random_traffic(90, 0, 69);
        test_random_traffic(90, 12, 12);
        s_valid         <= 1'b0;
        ready_stall_pct = 0;
        // drain, then allow time for any stray result
        while (expected_responses.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
